// ----- src/dcirpm_pkg.sv -----
// shared types and constants of the dc internal resistance pulse tester
`default_nettype none

package dcirpm_pkg;

   localparam int ADDR_W     = 5;
   localparam int DATA_W     = 64;
   localparam int CFG_TIME_W = 48;
   localparam int NOW_W      = 48;
   localparam int VOLT_W     = 26;
   localparam int CURR_W     = 24;
   localparam int MOHM_W     = 32;
   localparam int MILLI_W    = 10;
   localparam int DIVIDEND_W = VOLT_W + MILLI_W;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   localparam logic [MILLI_W-1:0] MILLI = MILLI_W'(1000);

   localparam logic [CFG_TIME_W-1:0] INTERVAL_RST = CFG_TIME_W'(60000000);
   localparam logic [CFG_TIME_W-1:0] DURATION_RST = CFG_TIME_W'(100000);
   localparam logic [CURR_W-1:0]     PULSE_I_RST  = CURR_W'(100000);

   // register indexes, paddr[4:3]
   localparam logic [1:0] REG_INTERVAL = 2'd0;
   localparam logic [1:0] REG_DURATION = 2'd1;
   localparam logic [1:0] REG_PULSE_I  = 2'd2;

   // request kinds
   localparam logic REQ_PROCESS = 1'b0;
   localparam logic REQ_REARM   = 1'b1;

   typedef struct packed {
      logic [CFG_TIME_W-1:0] interval_us;
      logic [CFG_TIME_W-1:0] pulse_duration_us;
      logic [CURR_W-1:0]     pulse_current_ua;
   } cfg_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EVAL = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;
      logic diff_load;
      logic rearm;
      logic start_pulse;
      logic end_pulse;
      logic mul;
      logic div_step;
      logic emit;
      logic sp_pulse;
      logic res_ok;
      logic res_rej;
   } cmd_type;

   typedef struct packed {
      logic is_rearm;
      logic in_range;
      logic phase;
      logic elapsed;
      logic plausible;
   } status_type;

endpackage

`default_nettype wire

// ----- src/dcirpm_regs.sv -----
// configuration registers behind the apb-style port
`default_nettype none

module dcirpm_regs
   import dcirpm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[4:3];
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval_us       <= INTERVAL_RST;
         cfg_ff.pulse_duration_us <= DURATION_RST;
         cfg_ff.pulse_current_ua  <= PULSE_I_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_INTERVAL: cfg_ff.interval_us       <= pwdata[CFG_TIME_W-1:0];
            REG_DURATION: cfg_ff.pulse_duration_us <= pwdata[CFG_TIME_W-1:0];
            REG_PULSE_I:  cfg_ff.pulse_current_ua  <= pwdata[CURR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_INTERVAL: prdata = DATA_W'(cfg_ff.interval_us);
         REG_DURATION: prdata = DATA_W'(cfg_ff.pulse_duration_us);
         REG_PULSE_I:  prdata = DATA_W'(cfg_ff.pulse_current_ua);
         default:      prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- src/dcirpm_ctrl.sv -----
// sequencing state machine: evaluate, multiply, divide, report
`default_nettype none

module dcirpm_ctrl
   import dcirpm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type              state_ff, state_in;
   logic      [CNT_W-1:0]  cnt_ff, cnt_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.diff_load = 1'b1;
            state_in      = ST_IDLE;
            priority if (status.is_rearm) begin
               cmd.rearm = status.in_range;
            end else if (!status.in_range) begin
               cmd.emit = 1'b1;
            end else if (!status.phase) begin
               cmd.emit        = 1'b1;
               cmd.sp_pulse    = status.elapsed;
               cmd.start_pulse = status.elapsed;
            end else if (!status.elapsed) begin
               cmd.emit     = 1'b1;
               cmd.sp_pulse = 1'b1;
            end else begin
               cmd.end_pulse = 1'b1;
               if (status.plausible) begin
                  state_in = ST_MUL;
               end else begin
                  cmd.emit    = 1'b1;
                  cmd.res_rej = 1'b1;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            cnt_in   = CNT_W'(DIV_STEPS - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.emit   = 1'b1;
            cmd.res_ok = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/dcirpm_dp.sv -----
// channel state, elapsed-time checks, multiply, radix-2 divider and result register
`default_nettype none

module dcirpm_dp
   import dcirpm_pkg::*;
#(
   parameter int CHANNELS  = 4,
   parameter int TIME_BITS = 48
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output status_type             status,
   input  wire cfg_type           cfg,
   input  wire logic              req_type,
   input  wire logic [1:0]        req_channel,
   input  wire logic [NOW_W-1:0]  req_now_us,
   input  wire logic [VOLT_W-1:0] req_voltage_uv,
   input  wire logic [CURR_W-1:0] req_current_ua,
   input  wire logic [CURR_W-1:0] req_target_ua,
   output logic                   rsp_strobe,
   output logic [CURR_W-1:0]      rsp_setpoint_ua,
   output logic                   rsp_res_valid,
   output logic [MOHM_W-1:0]      rsp_res_mohm,
   output logic                   rsp_res_rejected
);

   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CMP_W = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;

   // latched request
   logic                  kind_ff;
   logic [1:0]            chan_ff;
   logic [NOW_W-1:0]      now_ff;
   logic [VOLT_W-1:0]     volt_ff;
   logic [CURR_W-1:0]     curr_ff;
   logic [CURR_W-1:0]     target_ff;

   // per-channel state
   logic                  phase_ff [CHANNELS];
   logic [TIME_BITS-1:0]  last_ff  [CHANNELS];
   logic [TIME_BITS-1:0]  begin_ff [CHANNELS];
   logic [VOLT_W-1:0]     basev_ff [CHANNELS];
   logic [CURR_W-1:0]     basei_ff [CHANNELS];

   // arithmetic
   logic [VOLT_W-1:0]     dv_ff;
   logic [CURR_W-1:0]     di_ff;
   logic [DIVIDEND_W-1:0] dq_ff, dq_in;
   logic [CURR_W-1:0]     rem_ff, rem_in;
   logic [CURR_W:0]       shifted;

   // result register
   logic                  strobe_ff;
   logic [CURR_W-1:0]     setpoint_ff;
   logic                  valid_ff;
   logic [MOHM_W-1:0]     mohm_ff;
   logic                  rej_ff;

   logic [CH_W-1:0]       ch_idx;
   logic [TIME_BITS-1:0]  now_t;
   logic [TIME_BITS-1:0]  stamp;
   logic [TIME_BITS-1:0]  diff;
   logic [CFG_TIME_W-1:0] limit;
   logic [MOHM_W-1:0]     quot_sat;

   assign ch_idx = CH_W'(32'(chan_ff));
   assign now_t  = TIME_BITS'(now_ff);

   // elapsed time against the stamp that the current phase uses
   assign stamp = phase_ff[ch_idx] ? begin_ff[ch_idx] : last_ff[ch_idx];
   assign limit = phase_ff[ch_idx] ? cfg.pulse_duration_us : cfg.interval_us;
   assign diff  = now_t - stamp;

   assign status.is_rearm  = (kind_ff == REQ_REARM);
   assign status.in_range  = (32'(chan_ff) < 32'(CHANNELS));
   assign status.phase     = phase_ff[ch_idx];
   assign status.elapsed   = (CMP_W'(diff) >= CMP_W'(limit));
   assign status.plausible = (volt_ff > basev_ff[ch_idx]) && (basei_ff[ch_idx] > curr_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_type;
         chan_ff   <= req_channel;
         now_ff    <= req_now_us;
         volt_ff   <= req_voltage_uv;
         curr_ff   <= req_current_ua;
         target_ff <= req_target_ua;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            phase_ff[i] <= 1'b0;
            last_ff[i]  <= '0;
         end
      end else if (cmd.rearm || cmd.end_pulse) begin
         phase_ff[ch_idx] <= 1'b0;
         last_ff[ch_idx]  <= now_t;
      end else if (cmd.start_pulse) begin
         phase_ff[ch_idx] <= 1'b1;
      end
   end

   // only read while a pulse is held, so no reset needed
   always_ff @(posedge clock) begin
      if (cmd.start_pulse) begin
         begin_ff[ch_idx] <= now_t;
         basev_ff[ch_idx] <= volt_ff;
         basei_ff[ch_idx] <= curr_ff;
      end
   end

   // restoring division, one quotient bit a cycle
   assign shifted = {rem_ff, dq_ff[DIVIDEND_W-1]};

   always_comb begin
      dq_in  = dq_ff;
      rem_in = rem_ff;
      if (cmd.mul) begin
         dq_in  = DIVIDEND_W'(dv_ff) * DIVIDEND_W'(MILLI);
         rem_in = '0;
      end else if (cmd.div_step) begin
         if (shifted >= {1'b0, di_ff}) begin
            rem_in = CURR_W'(shifted - {1'b0, di_ff});
            dq_in  = {dq_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[CURR_W-1:0];
            dq_in  = {dq_ff[DIVIDEND_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.diff_load) begin
         dv_ff <= volt_ff - basev_ff[ch_idx];
         di_ff <= basei_ff[ch_idx] - curr_ff;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
   end

   assign quot_sat = (|dq_ff[DIVIDEND_W-1:MOHM_W]) ? '1 : dq_ff[MOHM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         setpoint_ff <= cmd.sp_pulse ? cfg.pulse_current_ua : target_ff;
         valid_ff    <= cmd.res_ok;
         mohm_ff     <= cmd.res_ok ? quot_sat : '0;
         rej_ff      <= cmd.res_rej;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_setpoint_ua  = setpoint_ff;
   assign rsp_res_valid    = valid_ff;
   assign rsp_res_mohm     = mohm_ff;
   assign rsp_res_rejected = rej_ff;

endmodule

`default_nettype wire

// ----- src/dcir_pulse_measure_core.sv -----
// top level of the per-channel dc internal resistance pulse tester
//
//   channel   direction  handshake                 payload
//   request   in         start / busy              req_type, req_channel, req_now_us,
//                                                  req_voltage_uv, req_current_ua, req_target_ua
//   result    out        rsp_strobe (one cycle)    rsp_setpoint_ua, rsp_res_valid,
//                                                  rsp_res_mohm, rsp_res_rejected
//   config    in/out     psel/penable/pready       paddr, pwrite, pwdata, prdata
//
// a request is taken when start is high and busy is low; one request at a time
// a result strobes from the register after the evaluate state, or, when a resistance is
// computed, after the multiply state, the 36-step radix-2 divider and the done state
// a rearm request gives no result and frees the block after the evaluate state
// synchronous reset clears phases, the interval time stamps and the registers to their defaults
// results cannot be stalled; each is strobed for exactly one cycle
`default_nettype none

module dcir_pulse_measure_core
   import dcirpm_pkg::*;
#(
   parameter int CHANNELS  = 4,
   parameter int TIME_BITS = 48
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_type,
   input  wire logic [1:0]        req_channel,
   input  wire logic [NOW_W-1:0]  req_now_us,
   input  wire logic [VOLT_W-1:0] req_voltage_uv,
   input  wire logic [CURR_W-1:0] req_current_ua,
   input  wire logic [CURR_W-1:0] req_target_ua,
   output logic                   rsp_strobe,
   output logic [CURR_W-1:0]      rsp_setpoint_ua,
   output logic                   rsp_res_valid,
   output logic [MOHM_W-1:0]      rsp_res_mohm,
   output logic                   rsp_res_rejected,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   dcirpm_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dcirpm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   dcirpm_dp #(
      .CHANNELS  (CHANNELS),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .cfg              (cfg),
      .req_type         (req_type),
      .req_channel      (req_channel),
      .req_now_us       (req_now_us),
      .req_voltage_uv   (req_voltage_uv),
      .req_current_ua   (req_current_ua),
      .req_target_ua    (req_target_ua),
      .rsp_strobe       (rsp_strobe),
      .rsp_setpoint_ua  (rsp_setpoint_ua),
      .rsp_res_valid    (rsp_res_valid),
      .rsp_res_mohm     (rsp_res_mohm),
      .rsp_res_rejected (rsp_res_rejected)
   );

   // every request passes through the evaluate state, so strobes never touch
   a_strobe_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe on two cycles in a row");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_res_valid && rsp_res_rejected))
      else $error("result both valid and rejected");

   a_mohm_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_res_valid) |-> (rsp_res_mohm == '0))
      else $error("resistance nonzero without a valid measurement");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but block not busy");

endmodule

`default_nettype wire
